// File: hdl/tone_queue_sequencer_top_defines.svh
// Assertion macros shared by the tone queue sequencer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TONE_QUEUE_SEQUENCER_TOP_DEFINES_SVH
`define TONE_QUEUE_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define TQS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tqs check failed");
// Next-cycle implication, disabled while reset is asserted
`define TQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tqs check failed");
`else
`define TQS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/tqs_pkg.sv
// Shared types and constants for the tone queue sequencer.
// No dependencies; used by tqs_cell and tone_queue_sequencer_top.
`timescale 1ns / 1ps
`default_nettype none

package tqs_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int TICK_MS_DEF     = 10;

    localparam int TONE_W    = 5;
    localparam int DUR_W     = 16;
    localparam int ELAPSED_W = 17;
    localparam int VOL_W     = 2;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 5;
    localparam int QCNT_W    = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 2'd0,
        CMD_QUEUE      = 2'd1,
        CMD_CONTINUOUS = 2'd2,
        CMD_STOP       = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'b001,
        MODE_PLAYING    = 3'b010,
        MODE_CONTINUOUS = 3'b100
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE = 8'd1;

    typedef struct packed {
        logic [TONE_W-1:0] tone;
        logic [DUR_W-1:0]  dur;
    } t_entry;

    // per-cell control: shift from upper neighbor, or load the new item
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: hdl/tone_queue_sequencer_top.sv
// Tone queue sequencer top level: command decode, tone timer, drive state,
// and a row of tqs_cell slots forming the shift queue. Depends on tqs_pkg,
// tqs_cell and tone_queue_sequencer_top_defines.svh.
// The result of a command is registered and appears in the cycle after it is taken.
// Throughput: one command per cycle; busy stays low, queue shift and timer
// compare both finish in the cycle of the command.
// Reset (synchronous, active low): idle, queue empty, drive off, other registers 0; queue slots are not reset.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

`include "tone_queue_sequencer_top_defines.svh"

module tone_queue_sequencer_top #(
    parameter int QUEUE_DEPTH = tqs_pkg::QUEUE_DEPTH_DEF,
    parameter int TICK_MS     = tqs_pkg::TICK_MS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // command channel
    input  wire                           start,
    output logic                          busy,
    input  wire  [tqs_pkg::CMD_W-1:0]     i_command,
    input  wire  [tqs_pkg::TONE_W-1:0]    i_tone,
    input  wire  [tqs_pkg::DUR_W-1:0]     i_duration_ms,
    // configuration write channel
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [tqs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [tqs_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // result
    output logic                          o_strobe,
    output logic                          o_drive_on,
    output logic [tqs_pkg::TONE_W-1:0]    o_drive_tone,
    output logic [tqs_pkg::VOL_W-1:0]     o_drive_volume,
    output logic                          o_indicator,
    output logic                          o_busy_res,
    output logic                          o_continuous,
    output logic [tqs_pkg::QCNT_W-1:0]    o_queue_count
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [tqs_pkg::VOL_W-1:0]  r_volume;
    logic [tqs_pkg::TONE_W-1:0] r_silence;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume  <= '0;
            r_silence <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == tqs_pkg::CFG_VOLUME) begin
                r_volume <= i_cfg_data[tqs_pkg::VOL_W-1:0];
            end else if (i_cfg_index == tqs_pkg::CFG_SILENCE) begin
                r_silence <= i_cfg_data[tqs_pkg::TONE_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    tqs_pkg::t_mode                r_mode,     n_mode;
    logic [CNT_W-1:0]              r_count,    n_count;
    logic [tqs_pkg::ELAPSED_W-1:0] r_elapsed,  n_elapsed;
    logic [tqs_pkg::DUR_W-1:0]     r_cur_dur,  n_cur_dur;
    logic                          r_drive_on, n_drive_on;
    logic [tqs_pkg::TONE_W-1:0]    r_drive_tone, n_drive_tone;
    logic [tqs_pkg::VOL_W-1:0]     r_drive_level, n_drive_level;
    logic                          r_ind,      n_ind;
    logic                          r_strobe;

    logic                          w_accept;
    logic                          w_pop;
    logic                          w_push;
    logic [tqs_pkg::ELAPSED_W-1:0] w_elapsed_inc;
    tqs_pkg::t_entry               w_head;
    tqs_pkg::t_entry               w_new;
    tqs_pkg::t_cell_ctl            w_ctl;

    // every command completes in the cycle it is taken, so the port never stalls
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_elapsed_inc = r_elapsed + tqs_pkg::ELAPSED_W'(TICK_MS);
    assign w_new         = '{tone: i_tone, dur: i_duration_ms};

    always_comb begin
        n_mode        = r_mode;
        n_count       = r_count;
        n_elapsed     = r_elapsed;
        n_cur_dur     = r_cur_dur;
        n_drive_on    = r_drive_on;
        n_drive_tone  = r_drive_tone;
        n_drive_level = r_drive_level;
        n_ind         = r_ind;
        w_pop         = 1'b0;
        w_push        = 1'b0;

        if (w_accept) begin
            case (tqs_pkg::t_cmd'(i_command))
                tqs_pkg::CMD_TICK: begin
                    if (r_mode == tqs_pkg::MODE_IDLE) begin
                        w_pop = (r_count != '0);
                    end else if (r_mode == tqs_pkg::MODE_PLAYING) begin
                        n_elapsed = w_elapsed_inc;
                        if (w_elapsed_inc >= {1'b0, r_cur_dur}) begin
                            if (r_count != '0) begin
                                w_pop = 1'b1;
                            end else begin
                                n_mode        = tqs_pkg::MODE_IDLE;
                                n_drive_on    = 1'b0;
                                n_drive_tone  = '0;
                                n_drive_level = '0;
                                n_ind         = 1'b0;
                            end
                        end
                    end
                end
                tqs_pkg::CMD_QUEUE: begin
                    // dropped when full or a continuous beep is running
                    if ((r_count < CNT_W'(QUEUE_DEPTH)) &&
                        (r_mode != tqs_pkg::MODE_CONTINUOUS)) begin
                        w_push  = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                tqs_pkg::CMD_CONTINUOUS: begin
                    n_mode        = tqs_pkg::MODE_CONTINUOUS;
                    n_count       = '0;
                    n_drive_on    = 1'b1;
                    n_drive_tone  = i_tone;
                    n_drive_level = r_volume;
                    n_ind         = 1'b1;
                end
                default: begin
                    // stop: queue is kept
                    n_mode        = tqs_pkg::MODE_IDLE;
                    n_drive_on    = 1'b0;
                    n_drive_tone  = '0;
                    n_drive_level = '0;
                    n_ind         = 1'b0;
                end
            endcase

            // start the head tone; the timer is not advanced on this tick
            if (w_pop) begin
                n_mode        = tqs_pkg::MODE_PLAYING;
                n_count       = r_count - 1'b1;
                n_elapsed     = '0;
                n_cur_dur     = w_head.dur;
                n_drive_on    = 1'b1;
                n_drive_tone  = w_head.tone;
                n_drive_level = r_volume;
                n_ind         = (w_head.tone != r_silence);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= tqs_pkg::MODE_IDLE;
            r_count       <= '0;
            r_elapsed     <= '0;
            r_cur_dur     <= '0;
            r_drive_on    <= 1'b0;
            r_drive_tone  <= '0;
            r_drive_level <= '0;
            r_ind         <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_mode        <= n_mode;
            r_count       <= n_count;
            r_elapsed     <= n_elapsed;
            r_cur_dur     <= n_cur_dur;
            r_drive_on    <= n_drive_on;
            r_drive_tone  <= n_drive_tone;
            r_drive_level <= n_drive_level;
            r_ind         <= n_ind;
            r_strobe      <= w_accept;
        end
    end

    // ---------------------------------------------------------------
    // Queue: row of slots, slot 0 is the head. On a pop every slot takes
    // its upper neighbor (the top slot keeps its own); a push writes the slot at the fill count.
    // ---------------------------------------------------------------
    tqs_pkg::t_entry w_slot [QUEUE_DEPTH];

    assign w_ctl.shift = w_pop;
    assign w_ctl.load  = w_push;
    assign w_head      = w_slot[0];

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        tqs_pkg::t_entry w_nbr;
        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_nbr = w_slot[g];
        end else begin : g_mid
            assign w_nbr = w_slot[g+1];
        end

        tqs_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (r_count),
            .i_nbr   (w_nbr),
            .i_new   (w_new),
            .o_entry (w_slot[g])
        );
    end

    // ---------------------------------------------------------------
    // Result ports: state after the command, registered and strobed in the cycle after the command, never later
    // ---------------------------------------------------------------
    logic [CNT_W+tqs_pkg::QCNT_W-1:0] w_count_ext;

    assign w_count_ext    = {{tqs_pkg::QCNT_W{1'b0}}, r_count};
    assign o_strobe       = r_strobe;
    assign o_drive_on     = r_drive_on;
    assign o_drive_tone   = r_drive_tone;
    assign o_drive_volume = r_drive_level;
    assign o_indicator    = r_ind;
    assign o_busy_res     = (r_mode != tqs_pkg::MODE_IDLE) || (r_count != '0);
    assign o_continuous   = (r_mode == tqs_pkg::MODE_CONTINUOUS);
    assign o_queue_count  = w_count_ext[tqs_pkg::QCNT_W-1:0];

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `TQS_ASSERT_SAME(a_off_clean, i_clk, i_rst_n, !r_drive_on, (r_drive_tone == '0) && (r_drive_level == '0))
    `TQS_ASSERT_SAME(a_idle_off, i_clk, i_rst_n, r_mode == tqs_pkg::MODE_IDLE, !r_drive_on)
    `TQS_ASSERT_SAME(a_cont_empty, i_clk, i_rst_n, r_mode == tqs_pkg::MODE_CONTINUOUS, r_count == '0)
    `TQS_ASSERT_SAME(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH))
    `TQS_ASSERT_NEXT(a_result, i_clk, i_rst_n, w_accept, r_strobe)

endmodule

`default_nettype wire

// File: hdl/tqs_cell.sv
// One queue slot: holds a tone entry, shifts toward the head on pop.
// Depends on tqs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tqs_cell #(
    parameter int CNT_W = 4,
    parameter int IDX   = 0
) (
    input  wire                        i_clk,
    input  wire  tqs_pkg::t_cell_ctl   i_ctl,
    input  wire  [CNT_W-1:0]           i_count,
    input  wire  tqs_pkg::t_entry      i_nbr,
    input  wire  tqs_pkg::t_entry      i_new,
    output tqs_pkg::t_entry            o_entry
);

    tqs_pkg::t_entry r_entry;
    tqs_pkg::t_entry n_entry;

    // load targets the first free slot only
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift) begin
            n_entry = i_nbr;
        end else if (i_ctl.load && (i_count == CNT_W'(IDX))) begin
            n_entry = i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire
